@@ rtl/core/pket_pkg.sv @@
// ---------------------------------------------------------------------------
// pket_pkg
// shared types and codes of the pair keyed entry table
// ---------------------------------------------------------------------------
`default_nettype none

package pket_pkg;

   localparam int ID_W     = 64;
   localparam int STATUS_W = 8;
   localparam int KNUM_W   = 32;
   localparam int KMAT_W   = 64;
   localparam int SLOT_W   = 4;
   localparam int OUTCOME_W = 2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUTCOME_DONE      = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_NO_SPACE  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]     client;
      logic [ID_W-1:0]     server;
      logic [STATUS_W-1:0] status;
      logic [KNUM_W-1:0]   key_number;
      logic [KMAT_W-1:0]   key_material;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/pket_req_if.sv @@
// ---------------------------------------------------------------------------
// pket_req_if
// request channel: valid/ready handshake with the request fields
// ---------------------------------------------------------------------------
`default_nettype none

interface pket_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [63:0] client_id;
   logic [63:0] server_id;
   logic [7:0]  entry_status;
   logic [31:0] key_number;
   logic [63:0] key_material;

   modport source (
      output valid, func, client_id, server_id, entry_status, key_number, key_material,
      input  ready
   );
   modport sink (
      input  valid, func, client_id, server_id, entry_status, key_number, key_material,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/pket_rsp_if.sv @@
// ---------------------------------------------------------------------------
// pket_rsp_if
// response channel: valid/ready handshake with the result fields
// ---------------------------------------------------------------------------
`default_nettype none

interface pket_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  outcome;
   logic [3:0]  slot_used;
   logic [7:0]  read_status;
   logic [31:0] read_key_number;
   logic [63:0] read_key_material;

   modport source (
      output valid, outcome, slot_used, read_status, read_key_number, read_key_material,
      input  ready
   );
   modport sink (
      input  valid, outcome, slot_used, read_status, read_key_number, read_key_material,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/core/pket_store.sv @@
// ---------------------------------------------------------------------------
// pket_store
// entry memory with one write port, one registered read port and per-entry
// valid bits; an entry never written since reset reads as all zero
// ---------------------------------------------------------------------------
`default_nettype none

module pket_store #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire logic [IDX_W-1:0]   rd_addr,
   output pket_pkg::entry_type     rd_entry,
   input  wire logic               wr_en,
   input  wire logic [IDX_W-1:0]   wr_addr,
   input  wire pket_pkg::entry_type wr_entry
);
   import pket_pkg::*;

   entry_type                  mem_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0]   valid_ff;
   logic [TABLE_ENTRIES-1:0]   valid_in;
   entry_type                  rd_data_ff;
   logic                       rd_valid_ff;
   logic                       rd_valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = rd_valid_ff;
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/core/pket_ctrl.sv @@
// ---------------------------------------------------------------------------
// pket_ctrl
// scan sequencer: walks the entries one per cycle through a shared compare
// unit, then writes back the entry of a write request and registers the result
// ---------------------------------------------------------------------------
`default_nettype none

module pket_ctrl #(
   parameter int TABLE_ENTRIES = 16,
   parameter int IDX_W         = 4,
   parameter int CNT_W         = 5
) (
   input  wire logic               clock,
   input  wire logic               reset,
   pket_req_if.sink                req_bus,
   pket_rsp_if.source              rsp_bus,
   output logic                    rd_en,
   output logic [IDX_W-1:0]        rd_addr,
   input  wire pket_pkg::entry_type rd_entry,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output pket_pkg::entry_type     wr_entry
);
   import pket_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(TABLE_ENTRIES);

   state_type              state_ff, state_in;
   logic                   func_ff, func_in;
   entry_type              req_ff, req_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   entry_type              hit_data_ff, hit_data_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [OUTCOME_W-1:0]   outcome_ff, outcome_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   entry_type              rdat_ff, rdat_in;

   logic                   accept;
   logic                   issue;
   logic                   load;
   logic                   is_match;
   logic                   is_free;
   logic                   scan_done;
   logic                   out_free;
   logic                   can_write;
   logic [IDX_W-1:0]       target_idx;

   // shared compare unit
   assign is_match  = (rd_entry.client == req_ff.client) && (rd_entry.server == req_ff.server);
   assign is_free   = (rd_entry == '0);
   assign scan_done = cmp_vld_ff && (is_match || (cmp_idx_ff == LAST_IDX));
   assign out_free  = !rsp_vld_ff || rsp_bus.ready;
   assign target_idx = hit_ff ? hit_idx_ff : free_idx_ff;
   assign can_write  = hit_ff || free_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_bus.ready = 1'b0;
      issue         = 1'b0;
      load          = 1'b0;
      wr_en         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_SCAN: begin
            issue = (cnt_ff < CNT_LIMIT);
         end
         ST_FINISH: begin
            load  = out_free;
            wr_en = out_free && (func_ff == FUNC_WRITE) && can_write;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   assign accept   = req_bus.valid && req_bus.ready;
   assign rd_en    = issue;
   assign rd_addr  = cnt_ff[IDX_W-1:0];
   assign wr_addr  = target_idx;
   assign wr_entry = req_ff;

   // datapath
   always_comb begin
      func_in     = func_ff;
      req_in      = req_ff;
      cnt_in      = cnt_ff;
      cmp_vld_in  = issue;
      cmp_idx_in  = cnt_ff[IDX_W-1:0];
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_data_in = hit_data_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      rsp_vld_in  = rsp_vld_ff;
      outcome_in  = outcome_ff;
      slot_in     = slot_ff;
      rdat_in     = rdat_ff;

      if (accept) begin
         func_in             = req_bus.func;
         req_in.client       = req_bus.client_id;
         req_in.server       = req_bus.server_id;
         req_in.status       = req_bus.entry_status;
         req_in.key_number   = req_bus.key_number;
         req_in.key_material = req_bus.key_material;
         cnt_in              = '0;
         hit_in              = 1'b0;
         free_in             = 1'b0;
      end

      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if ((state_ff == ST_SCAN) && cmp_vld_ff) begin
         if (is_match && !hit_ff) begin
            hit_in      = 1'b1;
            hit_idx_in  = cmp_idx_ff;
            hit_data_in = rd_entry;
         end
         if (is_free && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      if (load) begin
         rsp_vld_in = 1'b1;
         outcome_in = OUTCOME_DONE;
         slot_in    = '0;
         rdat_in    = '0;
         if (func_ff == FUNC_WRITE) begin
            if (can_write) begin
               slot_in = SLOT_W'(target_idx);
            end else begin
               outcome_in = OUTCOME_NO_SPACE;
            end
         end else begin
            if (hit_ff) begin
               slot_in = SLOT_W'(hit_idx_ff);
               rdat_in = hit_data_ff;
            end else begin
               outcome_in = OUTCOME_NOT_FOUND;
            end
         end
      end else if (rsp_vld_ff && rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         hit_ff     <= hit_in;
         free_ff    <= free_in;
         rsp_vld_ff <= rsp_vld_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      req_ff      <= req_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_data_ff <= hit_data_in;
      free_idx_ff <= free_idx_in;
      outcome_ff  <= outcome_in;
      slot_ff     <= slot_in;
      rdat_ff     <= rdat_in;
   end

   assign rsp_bus.valid             = rsp_vld_ff;
   assign rsp_bus.outcome           = outcome_ff;
   assign rsp_bus.slot_used         = slot_ff;
   assign rsp_bus.read_status       = rdat_ff.status;
   assign rsp_bus.read_key_number   = rdat_ff.key_number;
   assign rsp_bus.read_key_material = rdat_ff.key_material;

endmodule

`default_nettype wire

@@ rtl/core/pair_keyed_entry_table.sv @@
// ---------------------------------------------------------------------------
// pair_keyed_entry_table
// table of entries keyed by a client and server identifier pair
// ---------------------------------------------------------------------------
// A request either writes an entry (updating the first one whose identifiers
// match, else filling the first all-zero one) or reads the first matching
// entry. Every request is answered by exactly one response. The entries are
// scanned one per cycle through a single compare unit fed by the memory read
// port; the scan ends at the first matching entry, or after the last entry
// when none matches. A new request is taken once the previous one has left
// the sequencer; the response sits in an output register until its transfer.
// The table reads as all zero after reset with no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module pair_keyed_entry_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pket_req_if.sink    req_bus,
   pket_rsp_if.source  rsp_bus
);
   import pket_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_entry;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;

   pket_store #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

   pket_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry)
   );

endmodule

`default_nettype wire
